/* hw/rtl/ipmf_pkg.sv */
package ipmf_pkg;

    localparam int unsigned DEPTH = 64;

    localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_ONES = 8'hFF;

    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_LIST_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic       blocked;
    } t_result;

    // Command token walking the cell chain; done marks match, placement or shift
    typedef struct packed {
        logic        vld;
        logic [1:0]  command;
        logic [31:0] address;
        logic        done;
    } t_tok;

    // Entry handed one cell down while a remove closes the gap
    typedef struct packed {
        logic        en;
        logic        vld;
        logic [31:0] value;
    } t_pull;

    // A zero byte of a filter value is a wildcard
    function automatic logic [31:0] mask_of(input logic [31:0] v);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            if (v[8*k +: 8] != 8'd0) begin
                m[8*k +: 8] = BYTE_ONES;
            end
        end
        return m;
    endfunction

endpackage

/* hw/rtl/ip_mask_filter_table.sv */
// IPv4 access control list with byte-wildcard filters.
// Input: present a t_request on i_request with start high; it is taken at a
// clock edge where busy is low. command selects check, add or remove.
// Output: one t_result per item, shown on o_result for a single cycle with
// o_valid high. The receiver cannot stall; the result must be taken then.
// Config: i_cfg_we with i_cfg_wdata writes block_on_match (reset 1); write it
// only while the block is idle.
// Flow: the item enters a row of DEPTH cells, one per filter entry, and
// walks one cell per cycle; o_valid and o_result are registered from the
// last cell. busy stays high from acceptance until the item leaves the last
// cell, so no new item is taken while one is still in the row.
// Remove shifts later entries down one cell behind the walking item.
// Reset: synchronous, active low; empties the table, clears busy and o_valid
// and sets block_on_match. Entries need no clearing pass: each cell has a
// valid bit.
module ip_mask_filter_table
    import ipmf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_request,
    output logic     o_valid,
    output t_result  o_result,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata
);

    t_tok  w_tok  [0:DEPTH];
    t_pull w_pull [0:DEPTH];

    logic    r_busy;
    logic    r_valid;
    t_result r_result, n_result;
    logic    r_block_on_match;
    logic    accept;
    t_tok    tail;

    assign accept = start && !r_busy;

    assign w_tok[0] = '{vld: accept, command: i_request.command,
                        address: i_request.address, done: 1'b0};
    assign w_pull[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ipmf_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[i]),
            .o_tok  (w_tok[i+1]),
            .i_pull (w_pull[i+1]),
            .o_pull (w_pull[i])
        );
    end

    assign tail = w_tok[DEPTH];

    always_comb begin
        n_result = '0;
        case (tail.command)
            CMD_CHECK:  n_result.blocked = tail.done ? r_block_on_match : !r_block_on_match;
            CMD_ADD:    n_result.status  = tail.done ? ST_DONE : ST_LIST_FULL;
            CMD_REMOVE: n_result.status  = tail.done ? ST_DONE : ST_NOT_FOUND;
            default:    n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_valid          <= 1'b0;
            r_block_on_match <= 1'b1;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail.vld) begin
                r_busy <= 1'b0;
            end
            r_valid <= tail.vld;
            if (i_cfg_we) begin
                r_block_on_match <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    logic [DEPTH-1:0] live;
    for (genvar i = 0; i < DEPTH; i++) begin : g_live
        assign live[i] = w_tok[i+1].vld;
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(live))
        else $error("more than one item in the cell row");

    a_no_head_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pull[0].en)
        else $error("remove shift reached past the first cell");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accepting an item");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result shown without a finished item");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

/* hw/rtl/ipmf_cell.sv */
module ipmf_cell
    import ipmf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_tok  i_tok,
    output t_tok  o_tok,
    input  t_pull i_pull,
    output t_pull o_pull
);

    logic        r_vld, n_vld;
    logic [31:0] r_val, n_val;
    t_tok        r_tok;

    logic act, shifting, hit_check, hit_free, hit_eq, hit;

    always_comb begin
        act       = r_tok.vld && !r_tok.done;
        shifting  = r_tok.vld && r_tok.done && (r_tok.command == CMD_REMOVE);
        hit_check = r_vld && ((r_tok.address & mask_of(r_val)) == r_val);
        hit_free  = !r_vld || (r_val == FREE_MARK);
        hit_eq    = r_vld && (r_val == r_tok.address);

        case (r_tok.command)
            CMD_CHECK:  hit = hit_check;
            CMD_ADD:    hit = hit_free;
            CMD_REMOVE: hit = hit_eq;
            default:    hit = 1'b0;
        endcase

        n_vld = r_vld;
        n_val = r_val;
        // take the right neighbor's entry while a remove shifts past it
        if (i_pull.en) begin
            n_vld = i_pull.vld;
            n_val = i_pull.value;
        end
        // drop own entry; the right neighbor, if any, refills it next cycle
        if (shifting || (act && hit && r_tok.command == CMD_REMOVE)) begin
            n_vld = 1'b0;
        end
        if (act && hit && r_tok.command == CMD_ADD) begin
            n_vld = 1'b1;
            n_val = r_tok.address;
        end

        o_tok      = r_tok;
        o_tok.done = r_tok.done || (act && hit);

        o_pull.en    = shifting;
        o_pull.vld   = r_vld;
        o_pull.value = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_tok <= '0;
        end else begin
            r_vld <= n_vld;
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
